/* hdl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants for the bitmap page allocator: field widths, register
// indexes, reset values and result status codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGES_DEF   = 4096;
    localparam int MAX_RUN_DEF = 64;

    // Pages per bitmap memory word.
    localparam int WORD_BITS  = 8;
    localparam int PAGE_SHIFT = 12;

    localparam int COUNT_W = 7;
    localparam int PCNT_W  = 13;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic [1:0] REG_VIRT_BASE  = 2'd0;
    localparam logic [1:0] REG_PHYS_BASE  = 2'd1;
    localparam logic [1:0] REG_VIRT_COUNT = 2'd2;
    localparam logic [1:0] REG_PHYS_COUNT = 2'd3;

    localparam logic [31:0] VIRT_BASE_RST = 32'hC010_0000;
    localparam logic [31:0] PHYS_BASE_RST = 32'h0020_0000;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_VIRT = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_PHYS = 2'd2;
    localparam logic [STAT_W-1:0] ST_USER    = 2'd3;

endpackage

/* hdl/bitmap_page_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a virtual and a physical page bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tdata[6:0] page count, tuser pool
//   (0 kernel, 1 user). Each request yields one or more beats on m_axis:
//   tdata = virt_addr, phys_addr, status; tlast marks the final beat of the
//   request. Kernel requests give one status-ok beat per page, or a single
//   failure beat; if physical pages run out, the failure beat follows the
//   pages already given and nothing is returned to the maps.
//   Registers (APB, byte address 4*i): virt_base, phys_base, virt_page_count,
//   phys_page_count. Write them only while no request is in flight.
// Timing:
//   One request at a time. The virtual search reads one 8-page word of the
//   bitmap memory per cycle, then marks the words the run covers. For each
//   page the physical map is then searched, skipping fully used words.
// Reset:
//   Both maps are cleared by a pass over every bitmap word; no request is
//   taken meanwhile, register writes are.
// Stall:
//   A full output register holds the sequencer; a new request is accepted
//   once the previous one has issued its last beat into that register.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
    parameter int PAGES   = bpa_pkg::PAGES_DEF,
    parameter int MAX_RUN = bpa_pkg::MAX_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] page_count
    input  logic        s_axis_tuser,   // [0] pool_select
    // result
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] virt_addr, [63:32] phys_addr,
                                        // [65:64] status
    output logic        m_axis_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WB    = bpa_pkg::WORD_BITS;
    localparam int DEPTH = (PAGES + WB - 1) / WB;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = AW + 3;
    localparam int CW    = $clog2(PAGES + 1);
    localparam int NW    = bpa_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_VSCAN, S_VSET, S_PPRIME, S_PSCAN, S_PEMIT, S_FAIL
    } t_state;

    t_state r_state;

    // configuration
    logic [31:0]                 r_virt_base, r_phys_base;
    logic [bpa_pkg::PCNT_W-1:0]  r_vcount, r_pcount;
    logic [CW-1:0]               vlimit, plimit;
    logic                        cfg_wr;

    // request
    logic          r_pool;
    logic [NW-1:0] r_n, r_run, r_i;
    logic [AW-1:0] r_clr, r_vw, r_pw, r_sw;
    logic [IW-1:0] r_vstart, r_vend, r_vidx, r_pidx;
    logic [bpa_pkg::STAT_W-1:0] r_st;

    // memories
    logic [WB-1:0] vmem [DEPTH];
    logic [WB-1:0] pmem [DEPTH];
    logic [WB-1:0] r_vq, r_pq;
    logic [AW-1:0] v_ra, p_ra, v_wa, p_wa;
    logic [WB-1:0] v_wm, p_wm;
    logic          v_we, p_we, v_wd, p_wd;

    // search
    logic          v_found, v_last_word, p_found, p_last_word;
    logic [NW-1:0] v_run;
    logic [IW-1:0] v_hit, v_start, pos;
    logic [2:0]    p_j;

    // output
    logic                       r_o_valid, r_o_last;
    logic [31:0]                r_o_va, r_o_pa;
    logic [bpa_pkg::STAT_W-1:0] r_o_st;
    logic                       out_free;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_virt_base <= bpa_pkg::VIRT_BASE_RST;
            r_phys_base <= bpa_pkg::PHYS_BASE_RST;
            r_vcount    <= '0;
            r_pcount    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                bpa_pkg::REG_VIRT_BASE:  r_virt_base <= pwdata;
                bpa_pkg::REG_PHYS_BASE:  r_phys_base <= pwdata;
                bpa_pkg::REG_VIRT_COUNT: r_vcount    <= pwdata[bpa_pkg::PCNT_W-1:0];
                bpa_pkg::REG_PHYS_COUNT: r_pcount    <= pwdata[bpa_pkg::PCNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bpa_pkg::REG_VIRT_BASE:  prdata = r_virt_base;
            bpa_pkg::REG_PHYS_BASE:  prdata = r_phys_base;
            bpa_pkg::REG_VIRT_COUNT: prdata = 32'(r_vcount);
            bpa_pkg::REG_PHYS_COUNT: prdata = 32'(r_pcount);
        endcase
    end

    // saturate page counts to the map size
    assign vlimit = (32'(r_vcount) > 32'(PAGES)) ? CW'(PAGES) : CW'(r_vcount);
    assign plimit = (32'(r_pcount) > 32'(PAGES)) ? CW'(PAGES) : CW'(r_pcount);

    // ---------------- bitmap memories ----------------
    always_ff @(posedge i_clk) begin
        r_vq <= vmem[v_ra];
        if (v_we) begin
            for (int b = 0; b < WB; b++) begin
                if (v_wm[b]) vmem[v_wa][b] <= v_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pq <= pmem[p_ra];
        if (p_we) begin
            for (int b = 0; b < WB; b++) begin
                if (p_wm[b]) pmem[p_wa][b] <= p_wd;
            end
        end
    end

    // read ahead one word while scanning
    assign v_ra = (r_state == S_VSCAN) ? AW'(r_vw + 1'b1) : '0;
    assign p_ra = (r_state == S_PSCAN) ? AW'(r_pw + 1'b1) : r_pw;

    always_comb begin
        v_we = 1'b0; v_wa = r_sw; v_wm = '0; v_wd = 1'b1;
        p_we = 1'b0; p_wa = r_pw; p_wm = '0; p_wd = 1'b1;
        if (r_state == S_CLEAR) begin
            v_we = 1'b1; v_wa = r_clr; v_wm = '1; v_wd = 1'b0;
            p_we = 1'b1; p_wa = r_clr; p_wm = '1; p_wd = 1'b0;
        end else if (r_state == S_VSET) begin
            v_we = 1'b1;
            for (int b = 0; b < WB; b++) begin
                v_wm[b] = ({r_sw, 3'(b)} >= r_vstart) && ({r_sw, 3'(b)} <= r_vend);
            end
        end else if (r_state == S_PSCAN && p_found) begin
            p_we = 1'b1;
            p_wm = WB'(1) << p_j;
        end
    end

    // ---------------- word search ----------------
    always_comb begin
        v_run   = r_run;
        v_found = 1'b0;
        v_hit   = '0;
        pos     = '0;
        for (int j = 0; j < WB; j++) begin
            pos = {r_vw, 3'(j)};
            if (!v_found) begin
                if (32'(pos) < 32'(vlimit) && !r_vq[j]) begin
                    v_run = NW'(v_run + 1'b1);
                    if (v_run == r_n) begin
                        v_found = 1'b1;
                        v_hit   = pos;
                    end
                end else begin
                    v_run = '0;
                end
            end
        end
    end

    assign v_start     = IW'(v_hit - IW'(r_n) + 1'b1);
    assign v_last_word = (32'({r_vw, 3'b000}) + 32'd8) >= 32'(vlimit);
    assign p_last_word = (32'({r_pw, 3'b000}) + 32'd8) >= 32'(plimit);

    always_comb begin
        p_found = 1'b0;
        p_j     = '0;
        for (int j = 0; j < WB; j++) begin
            if (!p_found && 32'({r_pw, 3'(j)}) < 32'(plimit) && !r_pq[j]) begin
                p_found = 1'b1;
                p_j     = 3'(j);
            end
        end
    end

    // ---------------- sequencer ----------------
    assign out_free      = !r_o_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // emit states reload the output register themselves
            if (r_o_valid && m_axis_tready && r_state != S_PEMIT && r_state != S_FAIL)
                r_o_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= AW'(r_clr + 1'b1);
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pool  <= s_axis_tuser;
                        r_n     <= s_axis_tdata[NW-1:0];
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_vw  <= '0;
                    r_pw  <= '0;
                    r_run <= '0;
                    if (r_pool) begin
                        r_st    <= bpa_pkg::ST_USER;
                        r_state <= S_FAIL;
                    end else if (r_n == '0 || r_n > NW'(MAX_RUN)) begin
                        r_st    <= bpa_pkg::ST_NO_VIRT;
                        r_state <= S_FAIL;
                    end else begin
                        r_state <= S_VSCAN;
                    end
                end
                S_VSCAN: begin
                    if (v_found) begin
                        r_vstart <= v_start;
                        r_vend   <= v_hit;
                        r_sw     <= v_start[IW-1:3];
                        r_state  <= S_VSET;
                    end else if (v_last_word) begin
                        r_st    <= bpa_pkg::ST_NO_VIRT;
                        r_state <= S_FAIL;
                    end else begin
                        r_vw  <= AW'(r_vw + 1'b1);
                        r_run <= v_run;
                    end
                end
                S_VSET: begin
                    r_sw <= AW'(r_sw + 1'b1);
                    if (r_sw == r_vend[IW-1:3]) begin
                        r_i     <= '0;
                        r_vidx  <= r_vstart;
                        r_state <= S_PPRIME;
                    end
                end
                S_PPRIME: r_state <= S_PSCAN;
                S_PSCAN: begin
                    if (p_found) begin
                        r_pidx  <= {r_pw, p_j};
                        r_state <= S_PEMIT;
                    end else if (p_last_word) begin
                        r_st    <= bpa_pkg::ST_NO_PHYS;
                        r_state <= S_FAIL;
                    end else begin
                        r_pw <= AW'(r_pw + 1'b1);
                    end
                end
                S_PEMIT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_va    <= r_virt_base + (32'(r_vidx) << bpa_pkg::PAGE_SHIFT);
                        r_o_pa    <= r_phys_base + (32'(r_pidx) << bpa_pkg::PAGE_SHIFT);
                        r_o_st    <= bpa_pkg::ST_OK;
                        r_o_last  <= (NW'(r_i + 1'b1) == r_n);
                        r_i       <= NW'(r_i + 1'b1);
                        r_vidx    <= IW'(r_vidx + 1'b1);
                        r_state   <= (NW'(r_i + 1'b1) == r_n) ? S_IDLE : S_PPRIME;
                    end
                end
                S_FAIL: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_va    <= '0;
                        r_o_pa    <= '0;
                        r_o_st    <= r_st;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {6'b0, r_o_st, r_o_pa, r_o_va};
    assign m_axis_tlast  = r_o_last;

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == S_DEC)
        else $error("accepted request did not enter decode");
    a_run_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_VSCAN |-> r_run < r_n)
        else $error("carried run reached request size without a hit");
    a_run_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_VSET |-> 32'(r_vend) < 32'(vlimit))
        else $error("virtual run marked beyond page count");
    a_phys_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PEMIT |-> 32'(r_pidx) < 32'(plimit))
        else $error("physical page beyond page count");
`endif

endmodule

/* tb/tb_bitmap_page_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator
// Drives page requests through the allocator under several register settings
// and handshake idling patterns. A bitmap predictor in the testbench computes
// every expected result beat, and each output beat is checked in order.
// ----------------------------------------------------------------------------
module tb_bitmap_page_allocator;

    localparam int NPAGES = bpa_pkg::PAGES_DEF;
    localparam int CNT_W = bpa_pkg::COUNT_W;
    localparam int WDOG_LIMIT = 40000;

    typedef struct packed {
        logic [bpa_pkg::ADDR_W-1:0] virt_addr;
        logic [bpa_pkg::ADDR_W-1:0] phys_addr;
        logic [bpa_pkg::STAT_W-1:0] status;
        logic                       last;
    } t_page_beat;

    typedef struct {
        logic                       pool;
        logic [CNT_W-1:0]           count;
        logic                       has_exp;
        logic [bpa_pkg::STAT_W-1:0] exp_status;
    } t_req_row;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid, m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic m_axis_tlast;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    bitmap_page_allocator i_dut (.*);

    // predictor state
    logic [31:0] mdl_virt_base, mdl_phys_base;
    logic [bpa_pkg::PCNT_W-1:0] mdl_virt_cnt, mdl_phys_cnt;
    bit mdl_virt_map[NPAGES];
    bit mdl_phys_map[NPAGES];
    t_page_beat alloc_q[$];
    int fail_cnt = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_off = 0;
    int wdog = 0;
    bit stim_done = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_pages(logic [bpa_pkg::PCNT_W-1:0] n);
        return (n > NPAGES) ? NPAGES : int'(n);
    endfunction

    function automatic void predict_alloc(logic pool, logic [CNT_W-1:0] n);
        int vlimit, plimit, run, vstart, pidx;
        t_page_beat b;
        vlimit = clamp_pages(mdl_virt_cnt);
        plimit = clamp_pages(mdl_phys_cnt);
        vstart = -1;
        run = 0;
        if (pool) begin
            alloc_q.push_back('{0, 0, bpa_pkg::ST_USER, 1'b1});
            return;
        end
        if (n != 0 && n <= bpa_pkg::MAX_RUN_DEF) begin
            for (int i = 0; i < vlimit && vstart < 0; i++) begin
                if (!mdl_virt_map[i]) begin
                    run++;
                    if (run == n) vstart = i + 1 - n;
                end else begin
                    run = 0;
                end
            end
        end
        if (vstart < 0) begin
            alloc_q.push_back('{0, 0, bpa_pkg::ST_NO_VIRT, 1'b1});
            return;
        end
        for (int i = 0; i < n; i++) mdl_virt_map[vstart + i] = 1;
        for (int i = 0; i < n; i++) begin
            pidx = -1;
            for (int j = 0; j < plimit && pidx < 0; j++)
                if (!mdl_phys_map[j]) pidx = j;
            if (pidx < 0) begin
                alloc_q.push_back('{0, 0, bpa_pkg::ST_NO_PHYS, 1'b1});
                return;
            end
            mdl_phys_map[pidx] = 1;
            b.virt_addr = mdl_virt_base + 32'((vstart + i) << bpa_pkg::PAGE_SHIFT);
            b.phys_addr = mdl_phys_base + 32'(pidx << bpa_pkg::PAGE_SHIFT);
            b.status = bpa_pkg::ST_OK;
            b.last = (i + 1 == n);
            alloc_q.push_back(b);
        end
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            bpa_pkg::REG_VIRT_BASE:  mdl_virt_base = val;
            bpa_pkg::REG_PHYS_BASE:  mdl_phys_base = val;
            bpa_pkg::REG_VIRT_COUNT: mdl_virt_cnt = val[bpa_pkg::PCNT_W-1:0];
            default:                 mdl_phys_cnt = val[bpa_pkg::PCNT_W-1:0];
        endcase
    endtask

    task automatic drain_then_settle();
        s_axis_tvalid <= 0;
        while (alloc_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic send_req(logic pool, logic [CNT_W-1:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {1'b0, n};
        s_axis_tuser <= pool;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_alloc(pool, n);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 0;
        else
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_page_beat got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.virt_addr = m_axis_tdata[31:0];
            got.phys_addr = m_axis_tdata[63:32];
            got.status = m_axis_tdata[65:64];
            got.last = m_axis_tlast;
            if (alloc_q.size() == 0) begin
                $error("unexpected result beat %h", got);
                fail_cnt++;
            end else begin
                want = alloc_q.pop_front();
                if (got.virt_addr !== want.virt_addr) begin
                    $error("virt_addr exp %h got %h", want.virt_addr, got.virt_addr);
                    fail_cnt++;
                end
                if (got.phys_addr !== want.phys_addr) begin
                    $error("phys_addr exp %h got %h", want.phys_addr, got.phys_addr);
                    fail_cnt++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    fail_cnt++;
                end
                if (got.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: count cycles with no beat on either side and no register access
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            wdog <= 0;
        else if (!stim_done || alloc_q.size() != 0)
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    t_req_row dir_tab[] = '{
        '{1'b0, 7'd1,  1'b1, bpa_pkg::ST_NO_VIRT}, // counts zero after reset
        '{1'b1, 7'd1,  1'b1, bpa_pkg::ST_USER},
        '{1'b0, 7'd0,  1'b1, bpa_pkg::ST_NO_VIRT},
        '{1'b0, 7'd65, 1'b1, bpa_pkg::ST_NO_VIRT},
        '{1'b0, 7'd127,1'b1, bpa_pkg::ST_NO_VIRT},
        '{1'b1, 7'd127,1'b1, bpa_pkg::ST_USER},
        '{1'b1, 7'd0,  1'b1, bpa_pkg::ST_USER},
        '{1'b0, 7'd1,  1'b0, bpa_pkg::ST_OK},
        '{1'b0, 7'd64, 1'b0, bpa_pkg::ST_OK},
        '{1'b0, 7'd3,  1'b0, bpa_pkg::ST_OK},
        '{1'b0, 7'd64, 1'b0, bpa_pkg::ST_OK},
        '{1'b0, 7'd10, 1'b0, bpa_pkg::ST_OK},
        '{1'b0, 7'd42, 1'b0, bpa_pkg::ST_OK},
        '{1'b0, 7'd85, 1'b1, bpa_pkg::ST_NO_VIRT}
    };

    task automatic run_random(int n_items, int idle, int stall);
        logic pool;
        logic [CNT_W-1:0] n;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n_items; i++) begin
            pool = ($urandom_range(9) == 0);
            case ($urandom_range(9))
                0:       n = CNT_W'($urandom_range(127));
                1:       n = CNT_W'(64);
                2, 3:    n = CNT_W'($urandom_range(64, 1));
                default: n = CNT_W'($urandom_range(8, 1));
            endcase
            send_req(pool, n);
        end
        drain_then_settle();
    endtask

    initial begin
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        mdl_virt_base = bpa_pkg::VIRT_BASE_RST; mdl_phys_base = bpa_pkg::PHYS_BASE_RST;
        mdl_virt_cnt = 0; mdl_phys_cnt = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (600) @(posedge i_clk); // map clearing pass

        for (int r = 0; r < dir_tab.size(); r++) begin
            if (r == 7) begin
                drain_then_settle();
                reg_write(bpa_pkg::REG_VIRT_COUNT, 32'd200);
                reg_write(bpa_pkg::REG_PHYS_COUNT, 32'd150);
            end
            send_req(dir_tab[r].pool, dir_tab[r].count);
            if (dir_tab[r].has_exp && alloc_q[$].status !== dir_tab[r].exp_status) begin
                $error("status exp %0d predicted %0d", dir_tab[r].exp_status,
                       alloc_q[$].status);
                fail_cnt++;
            end
        end
        drain_then_settle();

        // extremes: max bases, wrap of addresses, a count above the map size
        reg_write(bpa_pkg::REG_VIRT_BASE, 32'hFFFF_F000);
        reg_write(bpa_pkg::REG_PHYS_BASE, 32'hFFFF_F000);
        reg_write(bpa_pkg::REG_VIRT_COUNT, 32'h1FFF);
        reg_write(bpa_pkg::REG_PHYS_COUNT, 32'd4096);
        run_random(40, 0, 0);

        // hold the receiver off so the block backs up its input
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            run_random(30, 81, 0);
        join

        reg_write(bpa_pkg::REG_VIRT_BASE, 32'h0);
        reg_write(bpa_pkg::REG_PHYS_BASE, $urandom);
        reg_write(bpa_pkg::REG_VIRT_COUNT, 32'd4096);
        reg_write(bpa_pkg::REG_PHYS_COUNT, 32'd0);
        run_random(20, 0, 81);

        reg_write(bpa_pkg::REG_VIRT_BASE, $urandom & 32'hFFFF_F000);
        reg_write(bpa_pkg::REG_VIRT_COUNT, 32'd3840);
        reg_write(bpa_pkg::REG_PHYS_COUNT, 32'd4000);
        run_random(40, 7, 7);

        reg_write(bpa_pkg::REG_PHYS_COUNT, 32'h1FFF);
        run_random(40, 0, 0);

        stim_done = 1;
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
